@@ hdl/abd_pkg.sv @@
// ----------------------------------------------------------------------------
// abd_pkg
// Types, constants and a shared function of the anchor box detection decoder.
// ----------------------------------------------------------------------------
package abd_pkg;

    localparam int MAX_CLASSES = 128;

    typedef struct packed {
        logic              mode;
        logic [1:0]        scale_level;
        logic [1:0]        anchor_slot;
        logic [7:0]        grid_x;
        logic [7:0]        grid_y;
        logic signed [15:0] logit_x;
        logic signed [15:0] logit_y;
        logic signed [15:0] logit_w;
        logic signed [15:0] logit_h;
        logic signed [15:0] logit_obj;
        logic signed [15:0] class_logit;
    } abd_in_t;

    typedef struct packed {
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
        logic [15:0]        det_score;
        logic [6:0]         class_id;
    } abd_out_t;

    localparam logic [1:0] REG_CONF    = 2'd0;
    localparam logic [1:0] REG_RATIO_W = 2'd1;
    localparam logic [1:0] REG_RATIO_H = 2'd2;
    localparam logic [1:0] REG_NCLS    = 2'd3;

    localparam logic MODE_HEADER = 1'b0;
    localparam logic MODE_CLASS  = 1'b1;

    typedef enum logic [3:0] {
        STEP_NONE, STEP_A, STEP_B, STEP_C, STEP_D, STEP_E, STEP_F, STEP_G,
        STEP_H, STEP_I, STEP_J, STEP_K, STEP_L, STEP_M
    } step_t;

    typedef struct packed {
        logic  hdr_load;
        logic  cls_load;
        step_t step;
    } abd_cmd_t;

    typedef struct packed {
        logic last_class;
        logic obj_passed;
        logic score_ok;
    } abd_stat_t;

    localparam logic [15:0] SIG_TAB [0:16] = '{
        16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
        16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
        16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
    };

    localparam logic [8:0] ANCHOR_TAB [0:2][0:5] = '{
        '{9'd12, 9'd16, 9'd19, 9'd36, 9'd40, 9'd28},
        '{9'd36, 9'd75, 9'd76, 9'd55, 9'd72, 9'd146},
        '{9'd142, 9'd110, 9'd192, 9'd243, 9'd459, 9'd401}
    };

    // Piecewise linear sigmoid, Q8.8 in and Q0.16 out.
    function automatic logic [15:0] sig_q16(input logic signed [15:0] x);
        logic [15:0] a;
        logic [8:0]  idx;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [22:0] frac;
        logic [15:0] r;
        a = x[15] ? 16'(-x) : 16'(x);
        idx = a[15:7];
        lo = SIG_TAB[5'(idx[3:0])];
        hi = SIG_TAB[5'(idx[3:0]) + 5'd1];
        frac = 23'(hi - lo) * 23'(a[6:0]);
        if (idx >= 9'd16)
        begin
            r = SIG_TAB[16];
        end
        else
        begin
            r = lo + 16'(frac >> 7);
        end
        return x[15] ? 16'(17'h10000 - {1'b0, r}) : r;
    endfunction

endpackage

@@ hdl/abd_ctrl.sv @@
// ----------------------------------------------------------------------------
// abd_ctrl
// Sequencer of the decoder: input handshake, cell tracking and box steps.
// ----------------------------------------------------------------------------
module abd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_mode,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  abd_pkg::abd_stat_t stat,
    output abd_pkg::abd_cmd_t  cmd
);
    import abd_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_A    = 14'b00000000000010,
        ST_B    = 14'b00000000000100,
        ST_C    = 14'b00000000001000,
        ST_D    = 14'b00000000010000,
        ST_E    = 14'b00000000100000,
        ST_F    = 14'b00000001000000,
        ST_G    = 14'b00000010000000,
        ST_H    = 14'b00000100000000,
        ST_I    = 14'b00001000000000,
        ST_J    = 14'b00010000000000,
        ST_K    = 14'b00100000000000,
        ST_L    = 14'b01000000000000,
        ST_M    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   open_reg, open_next;
    logic   ovalid_reg, ovalid_next;
    logic   accept;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = ovalid_reg;
    assign out_free  = !ovalid_reg || !out_stall;

    always_comb
    begin
        state_next   = state_reg;
        open_next    = open_reg;
        ovalid_next  = ovalid_reg && out_stall;
        cmd.hdr_load = accept && (in_mode == MODE_HEADER);
        cmd.cls_load = accept && (in_mode == MODE_CLASS) && open_reg;
        cmd.step     = STEP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.hdr_load)
                begin
                    open_next = 1'b1;
                end
                else if (cmd.cls_load && stat.last_class)
                begin
                    open_next = 1'b0;
                    if (stat.obj_passed)
                    begin
                        state_next = ST_A;
                    end
                end
            end
            ST_A: begin cmd.step = STEP_A; state_next = ST_B; end
            ST_B: begin cmd.step = STEP_B; state_next = ST_C; end
            ST_C: begin cmd.step = STEP_C; state_next = ST_D; end
            ST_D:
            begin
                cmd.step   = STEP_D;
                state_next = stat.score_ok ? ST_E : ST_IDLE;
            end
            ST_E: begin cmd.step = STEP_E; state_next = ST_F; end
            ST_F: begin cmd.step = STEP_F; state_next = ST_G; end
            ST_G: begin cmd.step = STEP_G; state_next = ST_H; end
            ST_H: begin cmd.step = STEP_H; state_next = ST_I; end
            ST_I: begin cmd.step = STEP_I; state_next = ST_J; end
            ST_J: begin cmd.step = STEP_J; state_next = ST_K; end
            ST_K: begin cmd.step = STEP_K; state_next = ST_L; end
            ST_L: begin cmd.step = STEP_L; state_next = ST_M; end
            ST_M:
            begin
                if (out_free)
                begin
                    cmd.step    = STEP_M;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            open_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            open_reg   <= open_next;
            ovalid_reg <= ovalid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state register not one-hot");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step == STEP_M) |-> out_free)
        else $error("result loaded over a pending one");
    a_score_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_D && !stat.score_ok) |=> (state_reg == ST_IDLE))
        else $error("low score did not abort");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cls_load && stat.last_class && stat.obj_passed) |=> (state_reg == ST_A))
        else $error("cell end did not start the box steps");
`endif

endmodule

@@ hdl/abd_dp.sv @@
// ----------------------------------------------------------------------------
// abd_dp
// Datapath of the decoder: registers, cell state, sigmoid and shared multiplier.
// ----------------------------------------------------------------------------
module abd_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  abd_pkg::abd_in_t   in_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  abd_pkg::abd_cmd_t  cmd,
    output abd_pkg::abd_stat_t stat,
    output abd_pkg::abd_out_t  out_data
);
    import abd_pkg::*;

    logic [15:0] thr_reg, rw_reg, rh_reg;
    logic [7:0]  ncls_reg;
    logic [1:0]  scale_reg, anchor_reg;
    logic [7:0]  col_reg, row_reg;
    logic signed [15:0] bl0_reg, bl1_reg, bl2_reg, bl3_reg;
    logic [15:0] obj_reg;
    logic        objp_reg;
    logic signed [15:0] best_reg;
    logic [6:0]  bcls_reg;
    logic [7:0]  cnt_reg;

    logic [15:0] sig_reg, score_reg;
    logic signed [31:0] cx_reg, cy_reg;
    logic [17:0] tsqw_reg, tsqh_reg;
    logic [26:0] w16_reg, h16_reg;
    logic signed [15:0] left_reg, top_reg;
    logic [15:0] width_reg;
    logic signed [50:0] prod_reg;
    abd_out_t    out_reg;

    logic signed [15:0] sig_in;
    logic [15:0] sig_val;
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic        mul_en;
    logic [7:0]  ncls_eff, cnt_next;
    logic [1:0]  scl_in, anc_in;
    logic [8:0]  aw, ah;
    logic signed [25:0] cbase;
    logic [16:0] sig2;

    function automatic logic signed [15:0] sat_s25(input logic signed [50:0] p);
        logic signed [50:0] t;
        t = p[50] ? ((p + 51'sd33554431) >>> 25) : (p >>> 25);
        if (t > 51'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (t < -51'sd32768)
        begin
            return 16'sh8000;
        end
        return t[15:0];
    endfunction

    function automatic logic [15:0] sat_u24(input logic signed [50:0] p);
        logic signed [50:0] t;
        t = p >>> 24;
        if (t > 51'sd65535)
        begin
            return 16'hFFFF;
        end
        return t[15:0];
    endfunction

    assign ncls_eff = (ncls_reg == 8'd0) ? 8'd1 :
                      (ncls_reg > 8'(MAX_CLASSES)) ? 8'(MAX_CLASSES) : ncls_reg;
    assign cnt_next = cnt_reg + 8'd1;
    assign stat.last_class = (cnt_next >= ncls_eff);
    assign stat.obj_passed = objp_reg;
    assign stat.score_ok   = (score_reg > thr_reg);
    assign scl_in = (in_data.scale_level == 2'd3) ? 2'd2 : in_data.scale_level;
    assign anc_in = (in_data.anchor_slot == 2'd3) ? 2'd2 : in_data.anchor_slot;
    assign aw = ANCHOR_TAB[scale_reg][{anchor_reg, 1'b0}];
    assign ah = ANCHOR_TAB[scale_reg][{anchor_reg, 1'b1}];
    assign sig2 = {sig_reg, 1'b0};
    assign cbase = $signed({1'b0, (cmd.step == STEP_C) ? col_reg : row_reg, 16'b0})
                 + $signed({9'b0, sig2}) - 26'sd32768;
    assign sig_val = sig_q16(sig_in);
    assign out_data = out_reg;

    always_comb
    begin
        case (cmd.step)
            STEP_A:  sig_in = best_reg;
            STEP_B:  sig_in = bl0_reg;
            STEP_C:  sig_in = bl1_reg;
            STEP_D:  sig_in = bl2_reg;
            STEP_E:  sig_in = bl3_reg;
            default: sig_in = in_data.logit_obj;
        endcase
    end

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (cmd.step) inside
            STEP_B:
            begin
                mul_a = $signed({17'b0, sig_reg});
                mul_b = $signed({2'b0, obj_reg});
            end
            STEP_E, STEP_F:
            begin
                mul_a = $signed({16'b0, sig2});
                mul_b = $signed({1'b0, sig2});
            end
            STEP_G:
            begin
                mul_a = $signed({15'b0, tsqw_reg});
                mul_b = $signed({9'b0, aw});
            end
            STEP_H:
            begin
                mul_a = $signed({15'b0, tsqh_reg});
                mul_b = $signed({9'b0, ah});
            end
            STEP_I:
            begin
                mul_a = {cx_reg, 1'b0} - $signed({6'b0, w16_reg});
                mul_b = $signed({2'b0, rw_reg});
            end
            STEP_J:
            begin
                mul_a = {cy_reg, 1'b0} - $signed({6'b0, h16_reg});
                mul_b = $signed({2'b0, rh_reg});
            end
            STEP_K:
            begin
                mul_a = $signed({6'b0, w16_reg});
                mul_b = $signed({2'b0, rw_reg});
            end
            STEP_L:
            begin
                mul_a = $signed({6'b0, h16_reg});
                mul_b = $signed({2'b0, rh_reg});
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= 16'd32768;
            rw_reg     <= 16'd256;
            rh_reg     <= 16'd256;
            ncls_reg   <= 8'd80;
            scale_reg  <= '0;
            anchor_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            obj_reg    <= '0;
            objp_reg   <= 1'b0;
            best_reg   <= 16'sh8000;
            bcls_reg   <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CONF:    thr_reg  <= cfg_data;
                    REG_RATIO_W: rw_reg   <= cfg_data;
                    REG_RATIO_H: rh_reg   <= cfg_data;
                    REG_NCLS:    ncls_reg <= cfg_data[7:0];
                    default:     ;
                endcase
            end
            if (cmd.hdr_load)
            begin
                scale_reg  <= scl_in;
                anchor_reg <= anc_in;
                col_reg    <= in_data.grid_x;
                row_reg    <= in_data.grid_y;
                obj_reg    <= sig_val;
                objp_reg   <= (sig_val > thr_reg);
                best_reg   <= 16'sh8000;
                bcls_reg   <= '0;
                cnt_reg    <= '0;
            end
            else if (cmd.cls_load)
            begin
                if (cnt_reg == 8'd0 || in_data.class_logit > best_reg)
                begin
                    best_reg <= in_data.class_logit;
                    bcls_reg <= cnt_reg[6:0];
                end
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hdr_load)
        begin
            bl0_reg <= in_data.logit_x;
            bl1_reg <= in_data.logit_y;
            bl2_reg <= in_data.logit_w;
            bl3_reg <= in_data.logit_h;
        end
        if (mul_en)
        begin
            prod_reg <= 51'(mul_a) * 51'(mul_b);
        end
        case (cmd.step) inside
            STEP_A, STEP_B, STEP_E: sig_reg <= sig_val;
            STEP_C:
            begin
                sig_reg   <= sig_val;
                score_reg <= prod_reg[31:16];
                cx_reg    <= 32'(cbase) <<< (3 + scale_reg);
            end
            STEP_D:
            begin
                sig_reg <= sig_val;
                cy_reg  <= 32'(cbase) <<< (3 + scale_reg);
            end
            STEP_F: tsqw_reg  <= prod_reg[33:16];
            STEP_G: tsqh_reg  <= prod_reg[33:16];
            STEP_H: w16_reg   <= prod_reg[26:0];
            STEP_I: h16_reg   <= prod_reg[26:0];
            STEP_J: left_reg  <= sat_s25(prod_reg);
            STEP_K: top_reg   <= sat_s25(prod_reg);
            STEP_L: width_reg <= sat_u24(prod_reg);
            STEP_M:
            begin
                out_reg.box_left   <= left_reg;
                out_reg.box_top    <= top_reg;
                out_reg.box_width  <= width_reg;
                out_reg.box_height <= sat_u24(prod_reg);
                out_reg.det_score  <= score_reg;
                out_reg.class_id   <= bcls_reg;
            end
            default: ;
        endcase
    end

endmodule

@@ hdl/anchor_box_detection_decode.sv @@
// ----------------------------------------------------------------------------
// anchor_box_detection_decode
// Decodes detector head items of one grid cell into at most one box.
// ----------------------------------------------------------------------------
// The input channel takes a header request (mode 0) that opens a cell, then
// one class request (mode 1) per class. Header and class requests may follow
// back to back while the block is idle. After the last class request, if
// objectness passed, the block runs twelve steps on one shared multiplier
// and sigmoid unit and then loads its output register; in_stall is high
// during those steps, and an early reject on the final score ends them
// after 4. The output register holds the result while out_stall is high;
// a new cell can stream in meanwhile, and the final step waits until the
// register is free. The configuration channel is always ready and takes
// writes at any time; write it only while the block is idle. Reset restores
// the register defaults, closes any open cell and drops any pending result.
// ----------------------------------------------------------------------------
module anchor_box_detection_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  abd_pkg::abd_in_t   in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output abd_pkg::abd_out_t  out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import abd_pkg::*;

    abd_cmd_t  cmd;
    abd_stat_t stat;

    assign cfg_ready = 1'b1;

    abd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_mode   (in_data.mode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    abd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams cell headers and class scores into the anchor box decoder, predicts
// each detection with an independent fixed point model of the head decode and
// compares every result field by field, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;
    import abd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    abd_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    abd_out_t out_data;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    anchor_box_detection_decode dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Decoder model state.
    logic [15:0] thr_q16, rw_q88, rh_q88;
    logic [7:0]  ncls_reg;
    logic [1:0]  m_scale, m_anchor;
    logic [7:0]  m_col, m_row;
    logic signed [15:0] m_tx, m_ty, m_tw, m_th;
    logic [15:0] m_obj;
    logic        m_obj_ok;
    logic signed [15:0] m_best;
    logic [6:0]  m_best_cls;
    logic [7:0]  m_count;
    logic        m_open;

    abd_out_t pending_dets[$];
    int  errors;
    int  idle_cycles;
    bit  quiet;

    localparam logic [15:0] SIGMOID_KNOTS [0:16] = '{
        16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
        16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
        16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
    };
    localparam int ANCHOR_WH [0:2][0:5] = '{
        '{12, 16, 19, 36, 40, 28},
        '{36, 75, 76, 55, 72, 146},
        '{142, 110, 192, 243, 459, 401}
    };

    function automatic longint sigmoid_q16(input logic signed [15:0] x);
        longint a, k, r;
        a = (x < 0) ? -longint'(x) : longint'(x);
        k = a >>> 7;
        if (k >= 16)
        begin
            r = SIGMOID_KNOTS[16];
        end
        else
        begin
            r = SIGMOID_KNOTS[k]
                + (((SIGMOID_KNOTS[k + 1] - SIGMOID_KNOTS[k]) * (a & 127)) >>> 7);
        end
        return (x < 0) ? 65536 - r : r;
    endfunction

    function automatic longint trunc_toward_zero(input longint v, input int sh);
        return (v < 0) ? -((-v) >>> sh) : (v >>> sh);
    endfunction

    function automatic logic [15:0] clamp_signed(input longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    function automatic logic [15:0] clamp_unsigned(input longint v);
        if (v > 65535) v = 65535;
        if (v < 0) v = 0;
        return 16'(v);
    endfunction

    task automatic predict_cell(input abd_in_t req);
        longint cl, lim, score, stride, aw, ah, cx, cy, tw, th, w16, h16;
        int sc, an;
        abd_out_t det;
        if (req.mode == MODE_HEADER)
        begin
            m_scale = (req.scale_level > 2) ? 2'd2 : req.scale_level;
            m_anchor = (req.anchor_slot > 2) ? 2'd2 : req.anchor_slot;
            m_col = req.grid_x;
            m_row = req.grid_y;
            m_tx = req.logit_x;
            m_ty = req.logit_y;
            m_tw = req.logit_w;
            m_th = req.logit_h;
            m_obj = 16'(sigmoid_q16(req.logit_obj));
            m_obj_ok = m_obj > thr_q16;
            m_best = -16'sd32768;
            m_best_cls = '0;
            m_count = '0;
            m_open = 1'b1;
            return;
        end
        if (!m_open) return;
        cl = req.class_logit;
        if (m_count == 0 || cl > longint'(m_best))
        begin
            m_best = req.class_logit;
            m_best_cls = m_count[6:0];
        end
        m_count = m_count + 8'd1;
        lim = (ncls_reg == 0) ? 1 : ((ncls_reg > MAX_CLASSES) ? MAX_CLASSES : ncls_reg);
        if (m_count < lim) return;
        m_open = 1'b0;
        if (!m_obj_ok) return;
        score = (sigmoid_q16(m_best) * longint'(m_obj)) >>> 16;
        if (score <= thr_q16) return;
        sc = m_scale;
        an = m_anchor;
        stride = 8 << sc;
        aw = ANCHOR_WH[sc][an * 2];
        ah = ANCHOR_WH[sc][an * 2 + 1];
        cx = (2 * sigmoid_q16(m_tx) - 32768 + (longint'(m_col) << 16)) * stride;
        cy = (2 * sigmoid_q16(m_ty) - 32768 + (longint'(m_row) << 16)) * stride;
        tw = 2 * sigmoid_q16(m_tw);
        th = 2 * sigmoid_q16(m_th);
        w16 = ((tw * tw) >>> 16) * aw;
        h16 = ((th * th) >>> 16) * ah;
        det.box_left = clamp_signed(trunc_toward_zero((2 * cx - w16) * rw_q88, 25));
        det.box_top = clamp_signed(trunc_toward_zero((2 * cy - h16) * rh_q88, 25));
        det.box_width = clamp_unsigned(trunc_toward_zero(w16 * rw_q88, 24));
        det.box_height = clamp_unsigned(trunc_toward_zero(h16 * rh_q88, 24));
        det.det_score = 16'(score);
        det.class_id = m_best_cls;
        pending_dets = {pending_dets, det};
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        $display("ERROR %0t: %s", $time, msg);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Output side: random stalls, checks each detection against the model.
    initial
    begin
        int wait_left;
        abd_out_t exp_det;
        out_stall = 1'b1;
        wait_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_dets.size() == 0)
                begin
                    report_mismatch("detection with none expected");
                end
                else
                begin
                    exp_det = pending_dets.pop_front();
                    if (out_data.box_left !== exp_det.box_left)
                        report_mismatch($sformatf("box_left %0d exp %0d",
                            out_data.box_left, exp_det.box_left));
                    if (out_data.box_top !== exp_det.box_top)
                        report_mismatch($sformatf("box_top %0d exp %0d",
                            out_data.box_top, exp_det.box_top));
                    if (out_data.box_width !== exp_det.box_width)
                        report_mismatch($sformatf("box_width %0d exp %0d",
                            out_data.box_width, exp_det.box_width));
                    if (out_data.box_height !== exp_det.box_height)
                        report_mismatch($sformatf("box_height %0d exp %0d",
                            out_data.box_height, exp_det.box_height));
                    if (out_data.det_score !== exp_det.det_score)
                        report_mismatch($sformatf("det_score %0d exp %0d",
                            out_data.det_score, exp_det.det_score));
                    if (out_data.class_id !== exp_det.class_id)
                        report_mismatch($sformatf("class_id %0d exp %0d",
                            out_data.class_id, exp_det.class_id));
                end
                wait_left = quiet ? 0 : $urandom_range(0, 18);
            end
            else if (wait_left > 0)
            begin
                wait_left--;
            end
            out_stall <= (wait_left > 0);
        end
    end

    // Watchdog on cycles without any accepted request or detection.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** anchor_box_detection_decode: FAILED **");
                $finish;
            end
        end
    end

    // The request stays valid after acceptance unless a gap follows.
    task automatic send_request(input abd_in_t req);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge clk); while (in_stall);
        predict_cell(req);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CONF: thr_q16 = val;
            REG_RATIO_W: rw_q88 = val;
            REG_RATIO_H: rh_q88 = val;
            default: ncls_reg = val[7:0];
        endcase
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_dets.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic abd_in_t random_request(input logic m);
        abd_in_t r;
        r = abd_in_t'({$urandom, $urandom, $urandom, $urandom});
        r.mode = m;
        return r;
    endfunction

    function automatic abd_in_t header_request(input logic signed [15:0] obj);
        abd_in_t r;
        r = random_request(MODE_HEADER);
        // Keep box logits moderate so most boxes stay in range.
        if ($urandom_range(0, 3) != 0)
        begin
            r.logit_x = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
            r.logit_y = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
            r.logit_w = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
            r.logit_h = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
            r.grid_x = 8'($urandom_range(0, 80));
            r.grid_y = 8'($urandom_range(0, 80));
        end
        r.logit_obj = obj;
        return r;
    endfunction

    function automatic abd_in_t class_request(input logic signed [15:0] v);
        abd_in_t r;
        r = random_request(MODE_CLASS);
        r.class_logit = v;
        return r;
    endfunction

    task automatic run_cell(input logic signed [15:0] obj, input int n, input bit hot);
        int k;
        send_request(header_request(obj));
        for (k = 0; k < n; k++)
        begin
            if (hot)
                send_request(class_request(16'($urandom_range(0, 4095))));
            else
                send_request(class_request(16'($urandom)));
        end
    endtask

    task automatic test_directed_extremes();
        abd_in_t r;
        int s;
        write_register(REG_NCLS, 16'd3);
        write_register(REG_CONF, 16'd0);
        send_request(class_request(16'sd100));
        for (s = 0; s < 4; s++)
        begin
            r = header_request(16'sh7fff);
            r.scale_level = 2'(s);
            r.anchor_slot = 2'(3 - s);
            r.grid_x = (s[0]) ? 8'hff : 8'h00;
            r.grid_y = (s[1]) ? 8'hff : 8'h00;
            r.logit_x = (s[0]) ? 16'sh7fff : -16'sh8000;
            r.logit_w = (s[1]) ? 16'sh7fff : -16'sh8000;
            send_request(r);
            send_request(class_request(-16'sh8000));
            send_request(class_request(16'sh7fff));
            send_request(class_request(16'sh7fff));
        end
        // Header while a cell is open drops the old cell.
        run_cell(16'sh0400, 1, 1'b1);
        run_cell(16'sh0400, 3, 1'b1);
        wait_idle();
    endtask

    task automatic test_class_count_edges();
        write_register(REG_NCLS, 16'd0);
        run_cell(16'sh0800, 2, 1'b1);
        wait_idle();
        write_register(REG_NCLS, 16'd255);
        write_register(REG_RATIO_W, 16'hffff);
        write_register(REG_RATIO_H, 16'h0000);
        run_cell(16'sh0800, 130, 1'b1);
        wait_idle();
        write_register(REG_NCLS, 16'd128);
        write_register(REG_RATIO_W, 16'h0001);
        write_register(REG_RATIO_H, 16'hffff);
        run_cell(16'sh0800, 128, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_phase(input logic [15:0] thr, input logic [15:0] rw,
                                     input logic [15:0] rh, input logic [7:0] nc,
                                     input int cells);
        int c;
        write_register(REG_CONF, thr);
        write_register(REG_RATIO_W, rw);
        write_register(REG_RATIO_H, rh);
        write_register(REG_NCLS, 16'(nc));
        for (c = 0; c < cells; c++)
        begin
            case ($urandom_range(0, 9))
                0: send_request(random_request(1'($urandom)));
                1: run_cell(16'($urandom), $urandom_range(0, nc), 1'b0);
                default: run_cell(16'($urandom_range(0, 2047)), nc, 1'b1);
            endcase
        end
        wait_idle();
    endtask

    initial
    begin
        errors = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_CONF;
        cfg_data = '0;
        thr_q16 = 16'd32768;
        rw_q88 = 16'd256;
        rh_q88 = 16'd256;
        ncls_reg = 8'd80;
        m_open = 1'b0;
        m_count = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_class_count_edges();
        test_random_phase(16'd32768, 16'd256, 16'd256, 8'd4, 20);
        test_random_phase(16'd0, 16'd640, 16'd360, 8'd1, 60);
        quiet = 1'b1;
        test_random_phase(16'd50000, 16'd1280, 16'd960, 8'd2, 50);
        quiet = 1'b0;
        test_random_phase(16'hffff, 16'hffff, 16'hffff, 8'd3, 20);
        test_random_phase(16'd20000, 16'd0, 16'd512, 8'd5, 20);
        if (errors == 0)
        begin
            $display("** anchor_box_detection_decode: PASSED **");
        end
        else
        begin
            $display("** anchor_box_detection_decode: FAILED **");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hdl/abd_pkg.sv
hdl/abd_ctrl.sv
hdl/abd_dp.sv
hdl/anchor_box_detection_decode.sv
test/testbench.sv
